// ===== rtl/rfe_pkg.sv =====
// shared types, constants and helper functions for the rtc-to-epoch converter
`timescale 1ns / 1ps

package rfe_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DaysWidth = 17;
  localparam int unsigned TodWidth  = 20;

  // register word index, taken from paddr[2]
  localparam logic RegBcdMode   = 1'b0;
  localparam logic RegHour24    = 1'b1;

  localparam logic [7:0]  PmMask      = 8'h80;
  localparam logic [7:0]  HourMask    = 8'h7F;
  localparam logic [8:0]  YearOffset  = 9'd30;   // 2000 - 1970
  localparam logic [8:0]  LeapOffset  = 9'd31;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [7:0]  NoonHour    = 8'd12;
  localparam logic [3:0]  DecIndex    = 4'd11;

  typedef struct packed {
    logic bcd_mode;
    logic hour_24_mode;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] year;
  } dec_stage_t;

  typedef struct packed {
    logic                 valid;
    logic [DaysWidth-1:0] days;
    logic [TodWidth-1:0]  tod;
  } cal_stage_t;

  typedef struct packed {
    logic                 valid;
    logic [DataWidth-1:0] day_secs;
    logic [TodWidth-1:0]  tod;
  } mul_stage_t;

  // nibbles above 9 are taken at face value
  function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bcd);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return bcd ? ((hi << 3) + (hi << 1) + lo) : b;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] idx, input logic leap);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    // leap years add one day from march on
    if (leap && (idx >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ===== rtl/rfe_regs.sv =====
// apb configuration registers: bcd mode and 24-hour mode
`timescale 1ns / 1ps

module rfe_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfe_pkg::AddrWidth-1:0] paddr,
  input  logic [rfe_pkg::DataWidth-1:0] pwdata,
  output logic [rfe_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output rfe_pkg::cfg_t                 cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bcd_mode     <= 1'b1;
      cfg.hour_24_mode <= 1'b1;
    end else if (wr_en) begin
      if (paddr[2] == rfe_pkg::RegBcdMode) begin
        cfg.bcd_mode <= pwdata[0];
      end else begin
        cfg.hour_24_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rfe_pkg::RegHour24) begin
      prdata[0] = cfg.hour_24_mode;
    end else begin
      prdata[0] = cfg.bcd_mode;
    end
  end

endmodule

// ===== rtl/rfe_decode.sv =====
// stage 1: bcd or binary decode of the raw clock bytes, 12-hour fixup
`timescale 1ns / 1ps

module rfe_decode (
  input  logic                clk,
  input  logic                rst,
  input  rfe_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic [7:0]          seconds_raw,
  input  logic [7:0]          minutes_raw,
  input  logic [7:0]          hours_raw,
  input  logic [7:0]          day_raw,
  input  logic [7:0]          month_raw,
  input  logic [7:0]          year_raw,
  output rfe_pkg::dec_stage_t dec
);

  logic [7:0] hour_low;
  logic [7:0] hour_dec;

  always_comb begin
    hour_low = rfe_pkg::decode_byte(hours_raw & rfe_pkg::HourMask, cfg.bcd_mode);
    if (hour_low == rfe_pkg::NoonHour) begin
      hour_low = 8'd0;
    end
    if ((hours_raw & rfe_pkg::PmMask) != 8'd0) begin
      hour_low = hour_low + rfe_pkg::NoonHour;
    end
    hour_dec = cfg.hour_24_mode ? rfe_pkg::decode_byte(hours_raw, cfg.bcd_mode) : hour_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else begin
      dec.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec.sec  <= rfe_pkg::decode_byte(seconds_raw, cfg.bcd_mode);
    dec.min  <= rfe_pkg::decode_byte(minutes_raw, cfg.bcd_mode);
    dec.hour <= hour_dec;
    dec.day  <= rfe_pkg::decode_byte(day_raw, cfg.bcd_mode);
    dec.mon  <= rfe_pkg::decode_byte(month_raw, cfg.bcd_mode);
    dec.year <= rfe_pkg::decode_byte(year_raw, cfg.bcd_mode);
  end

endmodule

// ===== rtl/rfe_calendar.sv =====
// stage 2: day count since 1970 and seconds within the day
`timescale 1ns / 1ps

module rfe_calendar (
  input  logic                clk,
  input  logic                rst,
  input  rfe_pkg::dec_stage_t dec,
  output rfe_pkg::cal_stage_t cal
);

  logic [8:0]                    years;
  logic [8:0]                    leap_days;
  logic [3:0]                    mon_idx;
  logic [rfe_pkg::DaysWidth-1:0] year_days;
  logic [rfe_pkg::DaysWidth-1:0] days_sum;
  logic [rfe_pkg::TodWidth-1:0]  tod_sum;

  always_comb begin
    years     = {1'b0, dec.year} + rfe_pkg::YearOffset;
    leap_days = ({1'b0, dec.year} + rfe_pkg::LeapOffset) >> 2;
    // month zero and anything past twelve count as december
    if ((dec.mon >= 8'd1) && (dec.mon <= 8'd12)) begin
      mon_idx = dec.mon[3:0] - 4'd1;
    end else begin
      mon_idx = rfe_pkg::DecIndex;
    end
    year_days = rfe_pkg::DaysWidth'({8'd0, years} * {8'd0, rfe_pkg::DaysPerYear});
    // year base is always above one, so day zero cannot underflow
    days_sum  = year_days
              + {8'd0, leap_days}
              + {8'd0, rfe_pkg::days_before(mon_idx, dec.year[1:0] == 2'd0)}
              + {9'd0, dec.day}
              - rfe_pkg::DaysWidth'(1);
    tod_sum   = {12'd0, dec.sec}
              + rfe_pkg::TodWidth'({6'd0, dec.min} * {8'd0, rfe_pkg::SecsPerMin})
              + rfe_pkg::TodWidth'({12'd0, dec.hour} * {8'd0, rfe_pkg::SecsPerHour});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.valid <= 1'b0;
    end else begin
      cal.valid <= dec.valid;
    end
  end

  always_ff @(posedge clk) begin
    cal.days <= days_sum;
    cal.tod  <= tod_sum;
  end

endmodule

// ===== rtl/rfe_scale.sv =====
// stages 3 and 4: days times 86400, then add time of day into the output register
`timescale 1ns / 1ps

module rfe_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  rfe_pkg::cal_stage_t           cal,
  output logic                          done,
  output logic [rfe_pkg::DataWidth-1:0] unix_seconds
);

  rfe_pkg::mul_stage_t mul;
  logic [2*rfe_pkg::DaysWidth-1:0] prod;

  assign prod = cal.days * rfe_pkg::SecsPerDay;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul.valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      mul.valid <= cal.valid;
      done      <= mul.valid;
    end
  end

  always_ff @(posedge clk) begin
    // result wraps modulo 2^32
    mul.day_secs <= prod[rfe_pkg::DataWidth-1:0];
    mul.tod      <= cal.tod;
    unix_seconds <= mul.day_secs + {12'd0, mul.tod};
  end

endmodule

// ===== rtl/rtc_fields_to_epoch_seconds_unit.sv =====
// top level: rtc field snapshot to seconds since 1970
//
// usage:
//   drive the six raw clock bytes and pulse start; a transaction is taken at
//   every rising edge with start high and busy low. busy is high only while
//   rst is asserted, so a new snapshot can be taken in every cycle.
//   the result appears on unix_seconds with done high for exactly one cycle,
//   after the transaction has passed four register stages (decode, calendar,
//   multiply, final add). throughput is one per cycle.
//   the receiver cannot stall: every done pulse must be captured as it comes.
//   configuration goes through the apb port: word 0 (address 0) bit 0 is
//   bcd_mode, word 1 (address 4) bit 0 is hour_24_mode, both reset to 1.
//   pready is always high; write only while no transaction is in flight.
//   reset is synchronous and clears every valid bit, so nothing in flight
//   survives it and done is low in the cycle after reset.
`timescale 1ns / 1ps

module rtc_fields_to_epoch_seconds_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfe_pkg::AddrWidth-1:0] paddr,
  input  logic [rfe_pkg::DataWidth-1:0] pwdata,
  output logic [rfe_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    seconds_raw,
  input  logic [7:0]                    minutes_raw,
  input  logic [7:0]                    hours_raw,
  input  logic [7:0]                    day_raw,
  input  logic [7:0]                    month_raw,
  input  logic [7:0]                    year_raw,
  output logic                          done,
  output logic [rfe_pkg::DataWidth-1:0] unix_seconds
);

  rfe_pkg::cfg_t       cfg;
  rfe_pkg::dec_stage_t dec;
  rfe_pkg::cal_stage_t cal;
  logic                accept;

  assign busy   = rst;
  assign accept = start && !busy;

  rfe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfe_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (accept),
    .seconds_raw (seconds_raw),
    .minutes_raw (minutes_raw),
    .hours_raw   (hours_raw),
    .day_raw     (day_raw),
    .month_raw   (month_raw),
    .year_raw    (year_raw),
    .dec         (dec)
  );

  rfe_calendar u_calendar (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .cal (cal)
  );

  rfe_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .cal          (cal),
    .done         (done),
    .unix_seconds (unix_seconds)
  );

  // every transaction yields a done pulse at the end of the pipeline
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("transaction did not produce a result");

  // no result without a matching earlier transaction
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without a matching transaction");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done pulse right after reset");

endmodule

// ===== test/tb_rtc_fields_to_epoch_seconds_unit.sv =====
// testbench for the rtc snapshot to epoch seconds converter
`timescale 1ns / 1ps

module tb_rtc_fields_to_epoch_seconds_unit;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] year;
  } snapshot_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rfe_pkg::AddrWidth-1:0] paddr = '0;
  logic [rfe_pkg::DataWidth-1:0] pwdata = '0;
  logic [rfe_pkg::DataWidth-1:0] prdata;
  logic                          pready;
  logic                          start = 1'b0;
  logic                          busy;
  logic [7:0]                    seconds_raw = '0;
  logic [7:0]                    minutes_raw = '0;
  logic [7:0]                    hours_raw = '0;
  logic [7:0]                    day_raw = '0;
  logic [7:0]                    month_raw = '0;
  logic [7:0]                    year_raw = '0;
  logic                          done;
  logic [rfe_pkg::DataWidth-1:0] unix_seconds;

  // shadow of the configuration registers
  logic bcd_sel = 1'b1;
  logic h24_sel = 1'b1;

  snapshot_t    pending_snaps[$];
  logic [31:0]  expected_secs[$];
  int unsigned  idle_pct = 0;
  int unsigned  errors = 0;
  snapshot_t    next_snap;
  logic [31:0]  want_secs;

  rtc_fields_to_epoch_seconds_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .seconds_raw  (seconds_raw),
    .minutes_raw  (minutes_raw),
    .hours_raw    (hours_raw),
    .day_raw      (day_raw),
    .month_raw    (month_raw),
    .year_raw     (year_raw),
    .done         (done),
    .unix_seconds (unix_seconds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] field_value(input logic [7:0] b, input logic bcd);
    return bcd ? ({28'd0, b[7:4]} * 32'd10 + {28'd0, b[3:0]}) : {24'd0, b};
  endfunction

  function automatic logic [31:0] epoch_seconds(input snapshot_t s, input logic bcd,
                                                input logic h24);
    logic [31:0] sec, min, hr, day, mon, yr, yrs, days, mdays;
    sec = field_value(s.sec, bcd);
    min = field_value(s.min, bcd);
    day = field_value(s.day, bcd);
    mon = field_value(s.mon, bcd);
    yr  = field_value(s.year, bcd);
    if (h24) begin
      hr = field_value(s.hour, bcd);
    end else begin
      // twelve o'clock counts as zero, pm adds twelve
      hr = field_value({1'b0, s.hour[6:0]}, bcd);
      if (hr == 32'd12) hr = 32'd0;
      if (s.hour[7]) hr = hr + 32'd12;
    end
    // month 0 and months above 12 fall back to december
    if (mon < 32'd1 || mon > 32'd12) mon = 32'd12;
    case (mon)
      32'd1:   mdays = 32'd0;
      32'd2:   mdays = 32'd31;
      32'd3:   mdays = 32'd59;
      32'd4:   mdays = 32'd90;
      32'd5:   mdays = 32'd120;
      32'd6:   mdays = 32'd151;
      32'd7:   mdays = 32'd181;
      32'd8:   mdays = 32'd212;
      32'd9:   mdays = 32'd243;
      32'd10:  mdays = 32'd273;
      32'd11:  mdays = 32'd304;
      default: mdays = 32'd334;
    endcase
    // years are 2000 + yr, leap every fourth year with no century rule
    if (yr[1:0] == 2'b00 && mon >= 32'd3) mdays = mdays + 32'd1;
    yrs  = yr + 32'd30;
    days = yrs * 32'd365 + (yrs + 32'd1) / 32'd4 + mdays + day - 32'd1;
    return sec + min * 32'd60 + hr * 32'd3600 + days * 32'd86400;
  endfunction

  function automatic logic [7:0] encode(input int unsigned v, input logic bcd);
    return bcd ? {4'(v / 10), 4'(v % 10)} : 8'(v);
  endfunction

  function automatic snapshot_t random_snapshot(input logic bcd, input logic h24);
    snapshot_t s;
    int unsigned h;
    if ($urandom_range(99) < 65) begin
      // well-formed calendar time with random content
      s.sec  = encode($urandom_range(59), bcd);
      s.min  = encode($urandom_range(59), bcd);
      s.day  = encode($urandom_range(31, 1), bcd);
      s.mon  = encode($urandom_range(12, 1), bcd);
      s.year = encode($urandom_range(99), bcd);
      if (h24) begin
        s.hour = encode($urandom_range(23), bcd);
      end else begin
        h = $urandom_range(12, 1);
        s.hour = encode(h, bcd) | ($urandom_range(1) ? rfe_pkg::PmMask : 8'h00);
      end
    end else begin
      s = snapshot_t'(48'({$urandom, $urandom}));
    end
    return s;
  endfunction

  // driver: one transaction per edge with start high and busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_secs.push_back(epoch_seconds({seconds_raw, minutes_raw, hours_raw,
                                               day_raw, month_raw, year_raw},
                                              bcd_sel, h24_sel));
      end
      if (!start || !busy) begin
        if (pending_snaps.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_snap = pending_snaps.pop_front();
          start       <= 1'b1;
          seconds_raw <= next_snap.sec;
          minutes_raw <= next_snap.min;
          hours_raw   <= next_snap.hour;
          day_raw     <= next_snap.day;
          month_raw   <= next_snap.mon;
          year_raw    <= next_snap.year;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done pulse must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_secs.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected result 0x%08h", unix_seconds);
      end else begin
        want_secs = expected_secs.pop_front();
        if (unix_seconds !== want_secs) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("mismatch on unix_seconds: expected 0x%08h, got 0x%08h",
                     want_secs, unix_seconds);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rfe_pkg::RegBcdMode) bcd_sel = val;
    else h24_sel = val;
  endtask

  task automatic set_mode(input logic bcd, input logic h24);
    write_reg(rfe_pkg::RegBcdMode, bcd);
    write_reg(rfe_pkg::RegHour24, h24);
  endtask

  // wait until every transaction is taken and every result has come back
  task automatic drain();
    while (pending_snaps.size() != 0 || start) @(posedge clk);
    while (expected_secs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pct);
    idle_pct = pct;
    repeat (count) pending_snaps.push_back(random_snapshot(bcd_sel, h24_sel));
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values: bcd, 24-hour
    run_random(40, 0);

    // directed corners in 12-hour bcd mode
    set_mode(1'b1, 1'b0);
    idle_pct = 0;
    pending_snaps.push_back('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    pending_snaps.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    pending_snaps.push_back('{8'h59, 8'h59, 8'h12, 8'h31, 8'h12, 8'h99});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h00});
    pending_snaps.push_back('{8'h30, 8'h15, 8'h81, 8'h15, 8'h06, 8'h24});
    pending_snaps.push_back('{8'h30, 8'h15, 8'h11, 8'h15, 8'h06, 8'h24});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h91, 8'h28, 8'h02, 8'h23});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h01, 8'h29, 8'h02, 8'h04});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h01, 8'h01, 8'h03, 8'h04});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h01, 8'h01, 8'h03, 8'h05});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h10, 8'h10, 8'h13, 8'h50});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h10, 8'h10, 8'h0A, 8'h50});
    pending_snaps.push_back('{8'h5F, 8'hAA, 8'hFF, 8'h3A, 8'hF0, 8'hAF});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h7F, 8'h00, 8'h01, 8'h00});
    pending_snaps.push_back('{8'hA5, 8'h5A, 8'h80, 8'h01, 8'h01, 8'h38});
    pending_snaps.push_back('{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00});
    drain();

    set_mode(1'b0, 1'b1);
    run_random(110, 0);
    set_mode(1'b1, 1'b0);
    run_random(110, 73);
    set_mode(1'b0, 1'b0);
    run_random(110, 9);
    set_mode(1'b1, 1'b1);
    run_random(110, 73);
    set_mode(1'b0, 1'b1);
    run_random(110, 9);
    set_mode(1'b1, 1'b0);
    run_random(110, 0);
    set_mode(1'b0, 1'b0);
    run_random(110, 73);

    if (expected_secs.size() != 0) errors = errors + 1;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
